### rtl/uetd_pkg.sv
// Shared types and constants for the UART edge-time decoder.
package uetd_pkg;

   localparam int TIME_W          = 32;  // edge timestamp width
   localparam int FRAC_W          = 8;   // fraction bits of the bit time
   localparam int BT_W            = 24;  // bit time register width
   localparam int FRAME_REG_W     = 5;   // frame length register width
   localparam int COUNT_W         = 16;  // batch byte counter width
   localparam int BYTE_W          = 8;
   localparam int MIN_FRAME_BITS  = 2;
   localparam int DEF_MAX_FRAME   = 16;
   localparam int CSR_IDX_W       = 2;

   // dividend is 2 * (interval << FRAC_W) + bit_time
   localparam int NUM_W           = TIME_W + FRAC_W + 2;
   localparam int DIV_STEPS       = NUM_W;
   localparam int STEP_W          = $clog2(DIV_STEPS + 1);
   localparam int DVR_W           = BT_W + 1;  // divisor is 2 * bit_time

   localparam logic [BT_W-1:0]        BIT_TIME_RST   = BT_W'(2222);
   localparam logic [FRAME_REG_W-1:0] FRAME_BITS_RST = FRAME_REG_W'(10);
   localparam logic [COUNT_W-1:0]     COUNT_MAX      = {COUNT_W{1'b1}};

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BIT_TIME   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_BITS = CSR_IDX_W'(1);

   typedef struct packed {
      logic [TIME_W-1:0] edge_time;
      logic              last_edge;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  data_byte;
      logic               byte_valid;
      logic               batch_done;
      logic [COUNT_W-1:0] bytes_in_batch;
   } rsp_type;

endpackage

### rtl/uart_edge_time_decoder.sv
// UART byte recovery from line-edge timestamps, with a serial run-length divider.
//
// Each accepted item is one line edge. The first edge of a batch only records its
// time; when it is also the last edge, it goes on to report the count. Every
// later edge forms the interval, then builds the dividend and checks the
// idle-line limit, then runs through the shared restoring divider (one
// quotient bit per cycle, one 26-bit compare and subtract), and then, once
// the result slot is free, updates the frame. The
// divider turns the interval into a run length, interval / bit_time rounded half
// up; only its low bits plus a sticky overflow flag are kept, since a run is
// always clamped to the bits still missing in the frame. Runs alternate low and
// high, starting low, and fill the frame word from bit 0. A completed frame
// yields frame bits 1..8 as data_byte; the last edge of a batch also yields a
// result with batch_done set and then clears the decoder. req_stall is high
// while an edge is being processed. Configuration is accepted only while idle.
// bit_time 0 acts as 1; frame_bits is clamped to 2..MAX_FRAME_BITS.
module uart_edge_time_decoder #(
   parameter int MAX_FRAME_BITS = uetd_pkg::DEF_MAX_FRAME
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  uetd_pkg::req_type              req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output uetd_pkg::rsp_type              rsp_payload,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [uetd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [uetd_pkg::BT_W-1:0]      csr_data
);

   localparam int FB_W   = $clog2(MAX_FRAME_BITS + 1);
   localparam int LIM_W  = uetd_pkg::BT_W + FB_W;
   localparam int SCL_W  = uetd_pkg::TIME_W + uetd_pkg::FRAC_W;
   localparam int REM_W  = uetd_pkg::DVR_W;
   localparam logic [FB_W-1:0] FB_MAX = FB_W'(MAX_FRAME_BITS);
   localparam logic [FB_W-1:0] FB_MIN = FB_W'(uetd_pkg::MIN_FRAME_BITS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   // configuration
   logic [uetd_pkg::BT_W-1:0]        bit_time_ff,   bit_time_in;
   logic [uetd_pkg::FRAME_REG_W-1:0] frame_bits_ff, frame_bits_in;

   // control and decoder state
   state_type                     state_ff,     state_in;
   logic                          have_prev_ff, have_prev_in;
   logic                          level_hi_ff,  level_hi_in;
   logic [FB_W-1:0]               filled_ff,    filled_in;
   logic [uetd_pkg::COUNT_W-1:0]  count_ff,     count_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [uetd_pkg::STEP_W-1:0]   step_ff,      step_in;

   // payload / datapath
   logic [uetd_pkg::TIME_W-1:0]   prev_time_ff, prev_time_in;
   logic [MAX_FRAME_BITS-1:0]     frame_ff,     frame_in;
   logic [uetd_pkg::TIME_W-1:0]   diff_ff,      diff_in;
   logic                          zero_ff,      zero_in;    // run forced to zero
   logic                          first_ff,     first_in;   // edge had no predecessor
   logic                          last_ff,      last_in;
   logic [uetd_pkg::NUM_W-1:0]    num_ff,       num_in;
   logic [REM_W-1:0]              rem_ff,       rem_in;
   logic [FB_W-1:0]               quo_ff,       quo_in;
   logic                          sat_ff,       sat_in;     // quotient overflowed quo_ff
   uetd_pkg::rsp_type             rsp_ff,       rsp_in;

   // combinational helpers
   logic [uetd_pkg::BT_W-1:0]        bt_eff;
   logic [REM_W-1:0]                 divisor;
   logic [uetd_pkg::FRAME_REG_W-1:0] fb_clamp;
   logic [FB_W-1:0]                  fb_eff;
   logic [LIM_W-1:0]                 limit;
   logic [SCL_W-1:0]                 scaled;
   logic [REM_W:0]                   shifted;
   logic                             take;
   logic [FB_W-1:0]                  missing;
   logic                             run_nz;
   logic [FB_W-1:0]                  run_n;
   logic [FB_W:0]                    filled_sum;
   logic [FB_W:0]                    filled_new;
   logic [MAX_FRAME_BITS-1:0]        mask;
   logic                             emit;
   logic                             slot_free;
   logic                             req_fire;

   assign bt_eff   = (bit_time_ff == '0) ? uetd_pkg::BT_W'(1) : bit_time_ff;
   assign divisor  = {bt_eff, 1'b0};
   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign csr_ready = (state_ff == ST_IDLE);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // effective frame length
   always_comb begin
      fb_clamp = frame_bits_ff;
      if (fb_clamp < uetd_pkg::FRAME_REG_W'(FB_MIN)) begin
         fb_clamp = uetd_pkg::FRAME_REG_W'(FB_MIN);
      end
      if (fb_clamp > uetd_pkg::FRAME_REG_W'(FB_MAX)) begin
         fb_clamp = uetd_pkg::FRAME_REG_W'(FB_MAX);
      end
      fb_eff = fb_clamp[FB_W-1:0];
   end

   // idle-line limit: an interval of a whole frame or more with no frame open
   assign limit  = LIM_W'(bt_eff) * LIM_W'(fb_eff);
   assign scaled = {diff_ff, {uetd_pkg::FRAC_W{1'b0}}};

   // one restoring divide step
   assign shifted = {rem_ff, num_ff[uetd_pkg::NUM_W-1]};
   assign take    = (shifted >= {1'b0, divisor});

   // frame update
   always_comb begin
      missing = (filled_ff < fb_eff) ? (fb_eff - filled_ff) : '0;
      run_nz  = !first_ff && !zero_ff && (sat_ff || (quo_ff != '0));
      if (last_ff || sat_ff || (quo_ff > missing)) begin
         run_n = missing;
      end else begin
         run_n = quo_ff;
      end
      filled_sum = {1'b0, filled_ff} + {1'b0, run_n};
      filled_new = run_nz ? filled_sum : {1'b0, filled_ff};
      for (int i = 0; i < MAX_FRAME_BITS; i++) begin
         mask[i] = ((FB_W+1)'(i) >= {1'b0, filled_ff}) && ((FB_W+1)'(i) < filled_sum);
      end
      emit = !first_ff && (filled_new >= {1'b0, fb_eff});
   end

   always_comb begin
      bit_time_in   = bit_time_ff;
      frame_bits_in = frame_bits_ff;
      state_in      = state_ff;
      have_prev_in  = have_prev_ff;
      level_hi_in   = level_hi_ff;
      filled_in     = filled_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      step_in       = step_ff;
      prev_time_in  = prev_time_ff;
      frame_in      = frame_ff;
      diff_in       = diff_ff;
      zero_in       = zero_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      num_in        = num_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      sat_in        = sat_ff;
      rsp_in        = rsp_ff;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            uetd_pkg::CSR_BIT_TIME:   bit_time_in   = csr_data;
            uetd_pkg::CSR_FRAME_BITS: frame_bits_in = csr_data[uetd_pkg::FRAME_REG_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               last_in      = req_payload.last_edge;
               first_in     = !have_prev_ff;
               diff_in      = req_payload.edge_time - prev_time_ff;
               zero_in      = (req_payload.edge_time <= prev_time_ff);
               prev_time_in = req_payload.edge_time;
               have_prev_in = 1'b1;
               if (have_prev_ff) begin
                  state_in = ST_PREP;
               end else if (req_payload.last_edge) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_PREP: begin
            num_in  = {1'b0, scaled, 1'b0} + uetd_pkg::NUM_W'(bt_eff);
            zero_in = zero_ff ||
                      ((filled_ff == '0) && (scaled >= SCL_W'(limit)));
            rem_in  = '0;
            quo_in  = '0;
            sat_in  = 1'b0;
            step_in = uetd_pkg::STEP_W'(uetd_pkg::DIV_STEPS);
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            num_in  = {num_ff[uetd_pkg::NUM_W-2:0], 1'b0};
            rem_in  = take ? REM_W'(shifted - {1'b0, divisor}) : shifted[REM_W-1:0];
            quo_in  = {quo_ff[FB_W-2:0], take};
            sat_in  = sat_ff || quo_ff[FB_W-1];
            step_in = step_ff - uetd_pkg::STEP_W'(1);
            if (step_ff == uetd_pkg::STEP_W'(1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
               if (run_nz) begin
                  frame_in    = level_hi_ff ? (frame_ff | mask) : (frame_ff & ~mask);
                  level_hi_in = !level_hi_ff;
               end
               filled_in = filled_new[FB_W-1:0];
               count_in  = count_ff;
               if (emit) begin
                  filled_in = '0;
                  if (count_ff != uetd_pkg::COUNT_MAX) begin
                     count_in = count_ff + uetd_pkg::COUNT_W'(1);
                  end
               end
               if (emit || last_ff) begin
                  rsp_valid_in          = 1'b1;
                  rsp_in.byte_valid     = emit;
                  rsp_in.batch_done     = last_ff;
                  rsp_in.bytes_in_batch = count_in;
                  rsp_in.data_byte      = '0;
                  if (emit) begin
                     rsp_in.data_byte = frame_in[uetd_pkg::BYTE_W:1];
                  end
               end
               if (last_ff) begin
                  have_prev_in = 1'b0;
                  prev_time_in = '0;
                  level_hi_in  = 1'b0;
                  frame_in     = '0;
                  filled_in    = '0;
                  count_in     = '0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_time_ff   <= uetd_pkg::BIT_TIME_RST;
         frame_bits_ff <= uetd_pkg::FRAME_BITS_RST;
         state_ff      <= ST_IDLE;
         have_prev_ff  <= 1'b0;
         level_hi_ff   <= 1'b0;
         filled_ff     <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         step_ff       <= '0;
         prev_time_ff  <= '0;
         frame_ff      <= '0;
      end else begin
         bit_time_ff   <= bit_time_in;
         frame_bits_ff <= frame_bits_in;
         state_ff      <= state_in;
         have_prev_ff  <= have_prev_in;
         level_hi_ff   <= level_hi_in;
         filled_ff     <= filled_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         step_ff       <= step_in;
         prev_time_ff  <= prev_time_in;
         frame_ff      <= frame_in;
      end
      diff_ff  <= diff_in;
      zero_ff  <= zero_in;
      first_ff <= first_in;
      last_ff  <= last_in;
      num_ff   <= num_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      sat_ff   <= sat_in;
      rsp_ff   <= rsp_in;
   end

`ifndef SYNTHESIS
   // divider remainder stays below the divisor
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (rem_ff < divisor))
      else $error("divider remainder out of range");

   // a partially filled frame never reaches the frame size limit
   assert property (@(posedge clock) disable iff (reset)
      filled_ff < FB_MAX)
      else $error("frame fill count too large");

   // a new result only comes out of the finish step
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> ($past(state_ff) == ST_FINISH))
      else $error("result raised outside finish");

   // a result without a byte is the end-of-batch report with a cleared byte
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.byte_valid) |-> (rsp_ff.batch_done && (rsp_ff.data_byte == '0)))
      else $error("empty result without batch end");
`endif

endmodule
